### rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor engine: register
// indexes, reset values, control character codes and the command record
// passed from the cursor front end to the output sequencer.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ENABLE        = 3'd0;
    localparam logic [2:0] REG_SCALE_LOG2    = 3'd1;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [2:0] REG_TEXT_TOP      = 3'd4;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 12;
    localparam int POS_WIDTH       = 12;
    localparam int CELL_WIDTH      = 6;
    localparam int GLYPH_WIDTH     = 7;

    // Register reset values
    localparam logic [1:0]  RST_SCALE_LOG2    = 2'd1;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [11:0] RST_TEXT_TOP      = 12'd28;

    // Scale codes
    localparam logic [1:0] SCALE_X1  = 2'd0;
    localparam logic [1:0] SCALE_X2  = 2'd1;
    localparam logic [1:0] SCALE_X4  = 2'd2;
    localparam logic [1:0] SCALE_SAT = 2'd3;

    // Character codes
    localparam logic [7:0] CH_BACKSPACE  = 8'd8;
    localparam logic [7:0] CH_TAB        = 8'd9;
    localparam logic [7:0] CH_NEWLINE    = 8'd10;
    localparam logic [7:0] CH_RETURN     = 8'd13;
    localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
    localparam logic [7:0] CH_LAST_PRINT  = 8'd127;
    localparam logic [6:0] CH_SUBST      = 7'd63;

    // Result kinds
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // One character's worth of work for the output sequencer
    typedef struct packed {
        logic                   has_draw;
        logic                   has_scroll;
        logic [GLYPH_WIDTH-1:0] glyph;
        logic [POS_WIDTH-1:0]   pos_x;
        logic [POS_WIDTH-1:0]   pos_y;
        logic [CELL_WIDTH-1:0]  cell_px;
    } tcc_cmd_t;

    // Cell size in pixels; scale code 3 saturates to 4x
    function automatic logic [CELL_WIDTH-1:0] cell_size(input logic [1:0] scale);
        logic [CELL_WIDTH-1:0] size;
        case (scale)
            SCALE_X1: size = 6'd8;
            SCALE_X2: size = 6'd16;
            default:  size = 6'd32;
        endcase
        return size;
    endfunction

endpackage

### rtl/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Configuration registers and cursor update. Classifies each accepted
// character, moves the cursor in the same cycle and pushes a command record
// for every character that produces a draw, a scroll or both.
// ----------------------------------------------------------------------------
module tcc_front #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tcc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [tcc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                 accept,
    input  logic [7:0]                           char_code,
    output logic                                 push,
    output tcc_pkg::tcc_cmd_t                    cmd
);

    localparam int CMPW = ((COORD_WIDTH > tcc_pkg::CFG_DATA_WIDTH) ?
                           COORD_WIDTH : tcc_pkg::CFG_DATA_WIDTH) + 1;

    logic        enable_reg;
    logic [1:0]  scale_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [11:0] top_reg;

    logic [COORD_WIDTH-1:0] col_reg, col_next;
    logic [COORD_WIDTH-1:0] row_reg, row_next;

    logic [tcc_pkg::CELL_WIDTH-1:0] cell_px;
    logic [COORD_WIDTH-1:0] cw;
    logic [COORD_WIDTH-1:0] tab;
    logic [COORD_WIDTH-1:0] top;
    logic [COORD_WIDTH-1:0] row_clamp;
    logic [COORD_WIDTH-1:0] col_adv;
    logic [COORD_WIDTH-1:0] tab_sum;
    logic                   draw;
    logic                   scroll;
    logic [tcc_pkg::GLYPH_WIDTH-1:0] glyph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            scale_reg  <= tcc_pkg::RST_SCALE_LOG2;
            width_reg  <= tcc_pkg::RST_SCREEN_WIDTH;
            height_reg <= tcc_pkg::RST_SCREEN_HEIGHT;
            top_reg    <= tcc_pkg::RST_TEXT_TOP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tcc_pkg::REG_ENABLE:        enable_reg <= cfg_data[0];
                tcc_pkg::REG_SCALE_LOG2:    scale_reg  <= cfg_data[1:0];
                tcc_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                tcc_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                tcc_pkg::REG_TEXT_TOP:      top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cell_px   = tcc_pkg::cell_size(scale_reg);
    assign cw        = COORD_WIDTH'(cell_px);
    assign tab       = COORD_WIDTH'({cell_px, 2'b00});
    assign top       = COORD_WIDTH'(top_reg);
    assign row_clamp = (row_reg < top) ? top : row_reg;
    assign col_adv   = col_reg + cw;
    assign tab_sum   = col_reg + tab;
    assign glyph     = (char_code < tcc_pkg::CH_FIRST_PRINT ||
                        char_code > tcc_pkg::CH_LAST_PRINT) ?
                       tcc_pkg::CH_SUBST : char_code[6:0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_clamp;
        draw     = 1'b0;
        case (char_code)
            tcc_pkg::CH_NEWLINE:
            begin
                col_next = '0;
                row_next = row_clamp + cw;
            end
            tcc_pkg::CH_RETURN:
            begin
                col_next = '0;
            end
            tcc_pkg::CH_BACKSPACE:
            begin
                if (col_reg >= cw)
                    col_next = col_reg - cw;
            end
            tcc_pkg::CH_TAB:
            begin
                col_next = tab_sum & ~(tab - COORD_WIDTH'(1));
            end
            default:
            begin
                draw = 1'b1;
                col_next = col_adv;
                // wrap when the next cell would cross the right edge
                if (CMPW'(col_adv) + CMPW'(cell_px) > CMPW'(width_reg))
                begin
                    col_next = '0;
                    row_next = row_clamp + cw;
                end
            end
        endcase
        scroll = (CMPW'(row_next) + CMPW'(cell_px) > CMPW'(height_reg));
        if (scroll)
            row_next = row_next - cw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept && enable_reg)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign push           = accept && enable_reg && (draw || scroll);
    assign cmd.has_draw   = draw;
    assign cmd.has_scroll = scroll;
    assign cmd.glyph      = glyph;
    assign cmd.pos_x      = tcc_pkg::POS_WIDTH'(col_reg);
    assign cmd.pos_y      = tcc_pkg::POS_WIDTH'(row_clamp);
    assign cmd.cell_px    = cell_px;

endmodule

### rtl/tcc_queue.sv
// ----------------------------------------------------------------------------
// tcc_queue
// Small register queue of command records between the cursor front end and
// the output sequencer.
// ----------------------------------------------------------------------------
module tcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcc_pkg::tcc_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tcc_pkg::tcc_cmd_t head
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    tcc_pkg::tcc_cmd_t entry_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CNTW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNTW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// Output sequencer. Turns each queued command into one or two results
// (draw, scroll, or draw followed by scroll) in a registered output stage.
// ----------------------------------------------------------------------------
module tcc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  tcc_pkg::tcc_cmd_t                 head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kind,
    output logic [tcc_pkg::GLYPH_WIDTH-1:0]   glyph_code,
    output logic [tcc_pkg::POS_WIDTH-1:0]     pos_x,
    output logic [tcc_pkg::POS_WIDTH-1:0]     pos_y,
    output logic [tcc_pkg::CELL_WIDTH-1:0]    scroll_rows,
    output logic                              last
);

    logic valid_reg;
    logic phase_reg, phase_next;
    logic load;
    logic emit_draw;

    logic                             kind_reg,  kind_next;
    logic [tcc_pkg::GLYPH_WIDTH-1:0]  glyph_reg, glyph_next;
    logic [tcc_pkg::POS_WIDTH-1:0]    x_reg,     x_next;
    logic [tcc_pkg::POS_WIDTH-1:0]    y_reg,     y_next;
    logic [tcc_pkg::CELL_WIDTH-1:0]   rows_reg,  rows_next;
    logic                             last_reg,  last_next;

    assign load      = head_valid && (!valid_reg || !out_stall);
    assign emit_draw = head.has_draw && !phase_reg;
    // hold the entry at the queue head when a draw is followed by a scroll
    assign pop       = load && !(emit_draw && head.has_scroll);

    always_comb
    begin
        phase_next = phase_reg;
        if (load)
            phase_next = !pop;
        if (emit_draw)
        begin
            kind_next  = tcc_pkg::KIND_DRAW;
            glyph_next = head.glyph;
            x_next     = head.pos_x;
            y_next     = head.pos_y;
            rows_next  = '0;
            last_next  = !head.has_scroll;
        end
        else
        begin
            kind_next  = tcc_pkg::KIND_SCROLL;
            glyph_next = '0;
            x_next     = '0;
            y_next     = '0;
            rows_next  = head.cell_px;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            glyph_reg <= glyph_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            rows_reg  <= rows_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid   = valid_reg;
    assign kind        = kind_reg;
    assign glyph_code  = glyph_reg;
    assign pos_x       = x_reg;
    assign pos_y       = y_reg;
    assign scroll_rows = rows_reg;
    assign last        = last_reg;

endmodule

### rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Pixel cursor for a text console with line wrap and scroll.
// ----------------------------------------------------------------------------
// Takes one character per cycle while in_stall is low. The cursor moves in
// the cycle the character is accepted; each character other than the four
// controls yields a draw command, and a character that pushes the cell row
// past the bottom also yields a scroll command, so a draw with a scroll
// yields two results in turn. A queue of QUEUE_DEPTH commands sits between
// the cursor and the output register, so input keeps flowing while results
// wait; in_stall rises only when that queue is full, and the sustained rate
// is one result per cycle at the output while out_stall is low. An accepted
// character's command is registered in the queue, then in the output register.
module text_console_cursor_engine #(
    parameter int COORD_WIDTH = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tcc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [tcc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           char_code,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 kind,
    output logic [tcc_pkg::GLYPH_WIDTH-1:0]      glyph_code,
    output logic [tcc_pkg::POS_WIDTH-1:0]        pos_x,
    output logic [tcc_pkg::POS_WIDTH-1:0]        pos_y,
    output logic [tcc_pkg::CELL_WIDTH-1:0]       scroll_rows,
    output logic                                 last
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_head_valid;
    tcc_pkg::tcc_cmd_t q_push_data;
    tcc_pkg::tcc_cmd_t q_head;

    assign in_stall = q_full;

    tcc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_valid && !q_full),
        .char_code (char_code),
        .push      (q_push),
        .cmd       (q_push_data)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    tcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .glyph_code  (glyph_code),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .scroll_rows (scroll_rows),
        .last        (last)
    );

endmodule

### rtl/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the text console cursor engine, bound to the top.
// ----------------------------------------------------------------------------
module tcc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic                                 kind,
    input logic [tcc_pkg::GLYPH_WIDTH-1:0]      glyph_code,
    input logic [tcc_pkg::POS_WIDTH-1:0]        pos_x,
    input logic [tcc_pkg::POS_WIDTH-1:0]        pos_y,
    input logic [tcc_pkg::CELL_WIDTH-1:0]       scroll_rows,
    input logic                                 last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(glyph_code)
            && $stable(pos_x) && $stable(pos_y) && $stable(scroll_rows) && $stable(last))
        else $error("result changed while stalled");

    // scroll carries one cell height and nothing else
    a_scroll_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tcc_pkg::KIND_SCROLL |->
            last && glyph_code == '0 && pos_x == '0 && pos_y == '0 &&
            (scroll_rows == 6'd8 || scroll_rows == 6'd16 || scroll_rows == 6'd32))
        else $error("malformed scroll result");

    // draw carries a printable code and no scroll amount
    a_draw_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tcc_pkg::KIND_DRAW |->
            scroll_rows == '0 && glyph_code >= 7'd32)
        else $error("malformed draw result");

    // a draw that is not last is followed at once by its scroll
    a_draw_then_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == tcc_pkg::KIND_DRAW && !last |=>
            out_valid && kind == tcc_pkg::KIND_SCROLL && last)
        else $error("draw without following scroll");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .glyph_code  (glyph_code),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .scroll_rows (scroll_rows),
    .last        (last)
);
